@@ rtl/bwbn_pkg.sv @@
`default_nettype none
package bwbn_pkg;

  localparam int MAX_BONES = 8;
  localparam int IDX_W     = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
  localparam int CNT_W     = $clog2(MAX_BONES + 1);
  localparam int ID_W      = 16;
  localparam int WT_W      = 16;
  // merged products and their sum, with headroom for all loaded entries
  localparam int ACC_W     = 2 * WT_W + CNT_W + 1;
  localparam int QUO_W     = WT_W;
  localparam int FRAC_W    = 15;
  localparam int DVD_W     = ACC_W + FRAC_W;

  localparam logic [WT_W-1:0] ONE_Q15 = WT_W'(32768);

  typedef enum logic [1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_GO     = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]      command;
    logic [ID_W-1:0] bone_id;
    logic [WT_W-1:0] bone_weight;
    logic [WT_W-1:0] blend_weight;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0] out_bone_id;
    logic [WT_W-1:0] out_weight;
    logic            valid_res;
    logic            overflow;
    logic            last;
  } rsp_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [WT_W-1:0] sat_q15(input logic [WT_W-1:0] x);
    return (x > ONE_Q15) ? ONE_Q15 : x;
  endfunction

endpackage
`default_nettype wire

@@ rtl/bwbn_div.sv @@
`default_nettype none
module bwbn_div
  import bwbn_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [ACC_W-1:0] divisor,
  output div_stat_t             stat,
  output logic      [QUO_W-1:0] quotient
);

  localparam int STEP_W = $clog2(QUO_W + 1);

  logic [ACC_W-1:0]  rem;
  logic [ACC_W-1:0]  dvs;
  logic [QUO_W-1:0]  lo;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic              done;

  logic [ACC_W:0] trial;
  logic [ACC_W:0] diff;
  logic           ge;

  // restoring division, one quotient bit per cycle; high dividend part is below divisor
  assign trial = {rem, lo[QUO_W-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem   <= ACC_W'(dividend[DVD_W-1:QUO_W]);
        lo    <= dividend[QUO_W-1:0];
        dvs   <= divisor;
        steps <= STEP_W'(QUO_W);
        busy  <= 1'b1;
      end else if (busy) begin
        rem   <= ge ? diff[ACC_W-1:0] : trial[ACC_W-1:0];
        lo    <= {lo[QUO_W-2:0], ge};
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = lo;

endmodule
`default_nettype wire

@@ rtl/bone_weight_blend_normalise.sv @@
`default_nettype none
// Channel  Handshake            Payload  Content
// req      req_valid/req_stall  req_t    command, bone_id, bone_weight, blend_weight
// rsp      rsp_valid/rsp_stall  rsp_t    out_bone_id, out_weight, valid_res, overflow, last
//
// A load is written in the idle state. A go multiplies each A entry into the result list,
// then per B entry compares it with one result entry at a time (one shared compare) and
// merges it on a match or else appends or drops it, then per result entry runs the divider
// (start, 16 divider steps, done, output) or emits one empty result; rsp_stall holds output.
// rst is synchronous and clears counts, sequencer and output valid; lists are not cleared.
// req_stall is high from a go until the last result transaction is taken.
module bone_weight_blend_normalise
  import bwbn_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_AMUL,
    S_AWR,
    S_BMUL,
    S_BSCAN,
    S_DSTART,
    S_DIV,
    S_EMIT
  } state_t;

  state_t state;

  logic [ID_W-1:0]  a_ids [MAX_BONES];
  logic [WT_W-1:0]  a_wts [MAX_BONES];
  logic [ID_W-1:0]  b_ids [MAX_BONES];
  logic [WT_W-1:0]  b_wts [MAX_BONES];
  logic [ID_W-1:0]  r_ids [MAX_BONES];
  logic [ACC_W-1:0] prod  [MAX_BONES];
  logic [CNT_W-1:0] a_count;
  logic [CNT_W-1:0] b_count;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] i;
  logic [CNT_W-1:0] j;
  logic [ACC_W-1:0] sum;
  logic [WT_W-1:0]  w;
  logic [WT_W-1:0]  inv;
  logic             ovf;
  logic [2*WT_W-1:0] mul;

  logic [IDX_W-1:0]  i_ix;
  logic [IDX_W-1:0]  j_ix;
  logic [IDX_W-1:0]  n_ix;
  logic [IDX_W-1:0]  rd_ix;
  logic [WT_W-1:0]   mul_a;
  logic [WT_W-1:0]   mul_b;
  logic [2*WT_W-1:0] mul_full;
  logic [ACC_W-1:0]  mul_ext;
  logic              accept;
  logic              div_start;
  logic [DVD_W-1:0]  dividend;
  logic [ACC_W-1:0]  divisor;
  div_stat_t         dstat;
  logic [QUO_W-1:0]  quotient;
  logic [WT_W-1:0]   w_sat;

  assign i_ix  = i[IDX_W-1:0];
  assign j_ix  = j[IDX_W-1:0];
  assign n_ix  = n[IDX_W-1:0];
  assign rd_ix = (state == S_BSCAN) ? j_ix : i_ix;

  assign mul_a    = (state == S_AMUL) ? a_wts[i_ix] : b_wts[i_ix];
  assign mul_b    = (state == S_AMUL) ? inv : w;
  assign mul_full = mul_a * mul_b;
  assign mul_ext  = ACC_W'(mul);

  assign w_sat = sat_q15(req.blend_weight);

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;

  assign div_start = (state == S_DSTART);
  assign dividend  = (sum != '0) ? {prod[rd_ix], FRAC_W'(0)} : DVD_W'(ONE_Q15);
  assign divisor   = (sum != '0) ? sum : ACC_W'(n);

  bwbn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .stat     (dstat),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    mul <= mul_full;
    if (rst) begin
      state     <= S_IDLE;
      a_count   <= '0;
      b_count   <= '0;
      n         <= '0;
      rsp_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (req.command)
              CMD_LOAD_A: begin
                if (a_count < CNT_W'(MAX_BONES)) begin
                  a_ids[a_count[IDX_W-1:0]] <= req.bone_id;
                  a_wts[a_count[IDX_W-1:0]] <= sat_q15(req.bone_weight);
                  a_count <= a_count + 1'b1;
                end
              end
              CMD_LOAD_B: begin
                if (b_count < CNT_W'(MAX_BONES)) begin
                  b_ids[b_count[IDX_W-1:0]] <= req.bone_id;
                  b_wts[b_count[IDX_W-1:0]] <= sat_q15(req.bone_weight);
                  b_count <= b_count + 1'b1;
                end
              end
              CMD_GO: begin
                w     <= w_sat;
                inv   <= ONE_Q15 - w_sat;
                n     <= '0;
                i     <= '0;
                sum   <= '0;
                ovf   <= 1'b0;
                state <= S_AMUL;
              end
              default: ;
            endcase
          end
        end
        S_AMUL: begin
          if (i < a_count) begin
            state <= S_AWR;
          end else begin
            i     <= '0;
            state <= S_BMUL;
          end
        end
        S_AWR: begin
          r_ids[n_ix] <= a_ids[i_ix];
          prod[n_ix]  <= mul_ext;
          sum         <= sum + mul_ext;
          n           <= n + 1'b1;
          i           <= i + 1'b1;
          state       <= S_AMUL;
        end
        S_BMUL: begin
          if (i < b_count) begin
            j     <= '0;
            state <= S_BSCAN;
          end else if (n == '0) begin
            rsp       <= '{out_bone_id: '0, out_weight: '0, valid_res: 1'b0,
                           overflow: 1'b0, last: 1'b1};
            rsp_valid <= 1'b1;
            state     <= S_EMIT;
          end else begin
            i     <= '0;
            state <= S_DSTART;
          end
        end
        S_BSCAN: begin
          if (j < n) begin
            if (r_ids[rd_ix] == b_ids[i_ix]) begin
              prod[rd_ix] <= prod[rd_ix] + mul_ext;
              sum         <= sum + mul_ext;
              i           <= i + 1'b1;
              state       <= S_BMUL;
            end else begin
              j <= j + 1'b1;
            end
          end else begin
            if (n < CNT_W'(MAX_BONES)) begin
              r_ids[n_ix] <= b_ids[i_ix];
              prod[n_ix]  <= mul_ext;
              sum         <= sum + mul_ext;
              n           <= n + 1'b1;
            end else begin
              ovf <= 1'b1;
            end
            i     <= i + 1'b1;
            state <= S_BMUL;
          end
        end
        S_DSTART: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (dstat.done) begin
            rsp       <= '{out_bone_id: r_ids[rd_ix], out_weight: quotient,
                           valid_res: 1'b1, overflow: ovf,
                           last: (i + 1'b1 == n)};
            rsp_valid <= 1'b1;
            state     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!rsp_stall) begin
            rsp_valid <= 1'b0;
            if (rsp.last) begin
              state <= S_IDLE;
            end else begin
              i     <= i + 1'b1;
              state <= S_DSTART;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_with_pending: assert property (@(posedge clk) disable iff (rst)
    !req_stall |-> !rsp_valid) else $error("input taken while result pending");

  a_counts_in_range: assert property (@(posedge clk) disable iff (rst)
    a_count <= CNT_W'(MAX_BONES) && b_count <= CNT_W'(MAX_BONES) &&
    n <= CNT_W'(MAX_BONES)) else $error("count beyond capacity");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.overflow |-> n == CNT_W'(MAX_BONES))
    else $error("overflow with room left");

  a_div_owned: assert property (@(posedge clk) disable iff (rst)
    dstat.busy || dstat.done |-> state == S_DIV) else $error("divider out of phase");

  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_DIV || $past(state) == S_BMUL)
    else $error("result raised from wrong state");
`endif

endmodule
`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
module testbench;
  import bwbn_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  bone_weight_blend_normalise u_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // stimulus backlog and expected influences
  req_t req_backlog[$];
  rsp_t pending_influences[$];

  // shadow copy of the influence lists
  logic [ID_W-1:0] a_ids[MAX_BONES];
  logic [WT_W-1:0] a_wts[MAX_BONES];
  logic [ID_W-1:0] b_ids[MAX_BONES];
  logic [WT_W-1:0] b_wts[MAX_BONES];
  int a_n = 0;
  int b_n = 0;

  int gen_a = 0;
  int gen_b = 0;
  int counted = 0;
  int go_count = 0;
  int load_count = 0;
  int results_seen = 0;
  int ovf_seen = 0;
  int mismatches = 0;

  int req_idle = 0;
  int req_steady = 0;
  int stall_left = 0;
  int stall_len;
  int rsp_steady = 0;
  rsp_t want;

  function automatic logic [WT_W-1:0] limit_to_one(logic [WT_W-1:0] x);
    return (x > 16'd32768) ? 16'd32768 : x;
  endfunction

  function automatic int pick_gap(inout int steady);
    int r;
    if (steady != 0) begin
      steady--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) steady = $urandom_range(20, 60);
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // update the shadow lists; on a go, blend, normalize and queue the results
  function automatic void track_request(req_t r);
    longint unsigned prod[MAX_BONES];
    logic [ID_W-1:0] ids[MAX_BONES];
    longint unsigned sum, bw, inv, p, v;
    int n;
    bit ovf, hit;
    rsp_t e;
    n = 0;
    sum = 0;
    ovf = 1'b0;
    case (r.command)
      CMD_LOAD_A: begin
        load_count++;
        if (a_n < MAX_BONES) begin
          a_ids[a_n] = r.bone_id;
          a_wts[a_n] = limit_to_one(r.bone_weight);
          a_n++;
        end
      end
      CMD_LOAD_B: begin
        load_count++;
        if (b_n < MAX_BONES) begin
          b_ids[b_n] = r.bone_id;
          b_wts[b_n] = limit_to_one(r.bone_weight);
          b_n++;
        end
      end
      CMD_GO: begin
        go_count++;
        bw = limit_to_one(r.blend_weight);
        inv = 32768 - bw;
        for (int i = 0; i < a_n; i++) begin
          ids[n] = a_ids[i];
          prod[n] = a_wts[i] * inv;
          n++;
        end
        for (int i = 0; i < b_n; i++) begin
          p = b_wts[i] * bw;
          hit = 1'b0;
          for (int j = 0; j < n && !hit; j++) begin
            if (ids[j] == b_ids[i]) begin
              prod[j] += p;
              hit = 1'b1;
            end
          end
          if (!hit) begin
            if (n < MAX_BONES) begin
              ids[n] = b_ids[i];
              prod[n] = p;
              n++;
            end else begin
              ovf = 1'b1;
            end
          end
        end
        if (n == 0) begin
          e = '0;
          e.last = 1'b1;
          pending_influences.push_back(e);
        end else begin
          for (int i = 0; i < n; i++) sum += prod[i];
          for (int i = 0; i < n; i++) begin
            if (sum != 0) v = (prod[i] * 32768) / sum;
            else v = 32768 / n;
            e.out_bone_id = ids[i];
            e.out_weight = v[WT_W-1:0];
            e.valid_res = 1'b1;
            e.overflow = ovf;
            e.last = (i == n - 1);
            pending_influences.push_back(e);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void queue_item(logic [1:0] cmd, logic [ID_W-1:0] id,
                                     logic [WT_W-1:0] wt, logic [WT_W-1:0] bw);
    req_t r;
    r.command = cmd;
    r.bone_id = id;
    r.bone_weight = wt;
    r.blend_weight = bw;
    req_backlog.push_back(r);
    counted++;
    case (cmd)
      CMD_LOAD_A: if (gen_a < MAX_BONES) gen_a++;
      CMD_LOAD_B: if (gen_b < MAX_BONES) gen_b++;
      default: ;
    endcase
  endfunction

  function automatic logic [WT_W-1:0] rand_weight();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 25) return 16'd32768;
    if (r < 40) return WT_W'($urandom_range(32769, 65535));
    return WT_W'($urandom_range(0, 32768));
  endfunction

  function automatic logic [ID_W-1:0] rand_id();
    if ($urandom_range(0, 1)) return ID_W'($urandom_range(0, 7));
    return ID_W'($urandom_range(0, 65535));
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) track_request(req);
      if (!req_valid || !req_stall) begin
        if (req_idle != 0) begin
          req_valid <= 1'b0;
          req_idle--;
        end else if (req_backlog.size() != 0) begin
          req <= req_backlog.pop_front();
          req_valid <= 1'b1;
          req_idle = pick_gap(req_steady);
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and output stall
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (pending_influences.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected transaction: id %h wt %h v %b o %b l %b",
                     rsp.out_bone_id, rsp.out_weight, rsp.valid_res, rsp.overflow, rsp.last);
        end else begin
          want = pending_influences.pop_front();
          results_seen++;
          if (rsp.overflow) ovf_seen++;
          if (rsp.out_bone_id !== want.out_bone_id || rsp.out_weight !== want.out_weight ||
              rsp.valid_res !== want.valid_res || rsp.overflow !== want.overflow ||
              rsp.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp id %h wt %h v %b o %b l %b, got id %h wt %h v %b o %b l %b",
                       want.out_bone_id, want.out_weight, want.valid_res, want.overflow,
                       want.last, rsp.out_bone_id, rsp.out_weight, rsp.valid_res,
                       rsp.overflow, rsp.last);
          end
        end
      end
      if (stall_left != 0) begin
        rsp_stall <= 1'b1;
        stall_left--;
      end else begin
        stall_len = pick_gap(rsp_steady);
        rsp_stall <= (stall_len != 0);
        stall_left = (stall_len != 0) ? stall_len - 1 : 0;
      end
    end
  end

  initial begin
    int pick;
    logic [ID_W-1:0] id;
    // empty lists, unused command
    queue_item(CMD_GO, 16'h0000, 16'h0000, 16'h0000);
    queue_item(CMD_GO, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_item(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // zero weight sums
    queue_item(CMD_LOAD_A, 16'h0005, 16'h0000, 16'h0000);
    queue_item(CMD_GO, 16'h0000, 16'h0000, 16'h8000);
    queue_item(CMD_LOAD_B, 16'h0005, 16'h0000, 16'h0000);
    queue_item(CMD_GO, 16'h0000, 16'h0000, 16'h4000);
    // weight above one saturates
    queue_item(CMD_LOAD_A, 16'hFFFF, 16'hFFFF, 16'h0000);
    queue_item(CMD_GO, 16'h0000, 16'h0000, 16'hFFFF);
    queue_item(CMD_GO, 16'h0000, 16'h0000, 16'h0000);
    // duplicate id in A, B merging with earlier B
    queue_item(CMD_LOAD_A, 16'h0005, 16'h1234, 16'h0000);
    queue_item(CMD_LOAD_B, 16'h0005, 16'h7FFF, 16'h0000);
    queue_item(CMD_LOAD_B, 16'h7777, 16'h8000, 16'h0000);
    queue_item(CMD_LOAD_B, 16'h7777, 16'h0001, 16'h0000);
    queue_item(CMD_GO, 16'h0000, 16'h0000, 16'h3000);
    queue_item(CMD_GO, 16'h0000, 16'h0000, 16'h8001);
    queue_item(CMD_LOAD_A, 16'h0000, 16'h8000, 16'h0000);
    queue_item(CMD_GO, 16'h0000, 16'h0000, 16'h0001);

    // B holds 0x7777, kept out of A, so a full A list forces overflow
    while (counted < 480) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        queue_item(CMD_UNUSED, rand_id(), rand_weight(), rand_weight());
      end else if (pick < ((gen_a == MAX_BONES && gen_b == MAX_BONES) ? 15 : 50)) begin
        id = rand_id();
        if ($urandom_range(0, 1)) begin
          if (id == 16'h7777) id = 16'h7776;
          queue_item(CMD_LOAD_A, id, rand_weight(), rand_weight());
        end else begin
          queue_item(CMD_LOAD_B, id, rand_weight(), rand_weight());
        end
      end else begin
        queue_item(CMD_GO, rand_id(), rand_weight(), rand_weight());
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (req_backlog.size() != 0 || req_valid) @(posedge clk);
    while (pending_influences.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("covered %0d blends and %0d loads (lists %0d/%0d full)", go_count, load_count,
             a_n, b_n);
    $display("checked %0d result transactions, %0d with overflow, %0d mismatches",
             results_seen, ovf_seen, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #25_000_000;
    $display("timeout with %0d results outstanding", pending_influences.size());
    $display("status: fail");
    $finish;
  end

endmodule
